// ===== design/lhm_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency histogram monitor package
// Shared constants, types and helper functions of the histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

   localparam int NUM_BINS    = 128;
   localparam int COUNT_WIDTH = 32;
   localparam int BIN_W       = $clog2(NUM_BINS);
   localparam int TS_W        = 64;
   localparam int OUT_W       = 32;
   localparam int BIN_INDEX_W = 7;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SHIFT_W     = 5;

   typedef enum logic [1:0] {
      CMD_SAMPLE   = 2'd0,
      CMD_READ_BIN = 2'd1,
      CMD_SUMMARY  = 2'd2,
      CMD_CLEAR    = 2'd3
   } command_type;

   typedef enum logic {
      CSR_RANGE_START    = 1'b0,
      CSR_BIN_STEP_SHIFT = 1'b1
   } csr_index_type;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(3);
   localparam logic [TS_W-1:0]    S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [TS_W-1:0]    S64_MIN     = 64'h8000_0000_0000_0000;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [31:0]        range_start;
      logic [SHIFT_W-1:0] bin_step_shift;
   } cfg_type;

   function automatic count_type sat_inc(input count_type c);
      return (c == '1) ? c : c + count_type'(1);
   endfunction

   function automatic logic [OUT_W-1:0] cap_out(input count_type c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
   endfunction

endpackage

// ===== design/lhm_if.sv =====
// ----------------------------------------------------------------------------
// Latency histogram monitor channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface lhm_req_if import lhm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   logic [TS_W-1:0]        timestamp;
   logic [BIN_INDEX_W-1:0] bin_index;

   modport source (output valid, command, timestamp, bin_index, input ready);
   modport sink (input valid, command, timestamp, bin_index, output ready);
endinterface

interface lhm_rsp_if import lhm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OUT_W-1:0]       bin_count;
   logic [OUT_W-1:0]       overflow_count;
   logic [OUT_W-1:0]       underflow_count;
   logic signed [TS_W-1:0] min_difference;
   logic signed [TS_W-1:0] max_difference;
   logic                   sample_counted;

   modport source (output valid, bin_count, overflow_count, underflow_count,
                   min_difference, max_difference, sample_counted, input ready);
   modport sink (input valid, bin_count, overflow_count, underflow_count,
                 min_difference, max_difference, sample_counted, output ready);
endinterface

// ===== design/lhm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lhm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lhm_csr.sv =====
// ----------------------------------------------------------------------------
// Latency histogram monitor registers
// APB register file holding the range start and the bin step shift.
// ----------------------------------------------------------------------------
module lhm_csr import lhm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   csr_index_type index;

   assign index  = csr_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_start    <= '0;
         cfg_ff.bin_step_shift <= SHIFT_RESET;
      end else if (wr_en) begin
         unique case (index)
            CSR_RANGE_START:    cfg_ff.range_start    <= pwdata[31:0];
            CSR_BIN_STEP_SHIFT: cfg_ff.bin_step_shift <= pwdata[SHIFT_W-1:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_RANGE_START:    prdata = CSR_DATA_W'(cfg_ff.range_start);
         CSR_BIN_STEP_SHIFT: prdata = CSR_DATA_W'(cfg_ff.bin_step_shift);
         default:            prdata = '0;
      endcase
   end

endmodule

// ===== design/latency_histogram_monitor.sv =====
// ----------------------------------------------------------------------------
// Latency histogram monitor
// Histograms the signed interval between successive timestamps and keeps
// overflow, underflow, minimum and maximum statistics.
// ----------------------------------------------------------------------------
// Command words arrive on req_chan and every command returns exactly one
// result word on rsp_chan. A sample word records the interval from the
// previous sample, the first sample after reset or clear only primes the
// stored timestamp. Other words read one bin, read the summary, or clear
// all statistics. The APB port sets the range start and the bin step shift.
// The user must write it only while the monitor is idle; the block does not enforce this.
// One word is processed at a time: a new command word is accepted only once
// the previous word has updated the statistics and registered its result.
// Each word passes in turn through the subtract, offset, shift and bin
// memory read-modify-write steps.
// If the receiver stalls, the result waits in the output register while the
// next word is accepted and worked on; that word then waits before its
// update until the output register is free.
// Reset clears the statistics at once through per-bin valid bits, so no
// clearing pass is needed; the clear command clears the valid bits the same way.
// ----------------------------------------------------------------------------
module latency_histogram_monitor import lhm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lhm_req_if.sink               req_chan,
   lhm_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_OFFS,
      ST_LOOK,
      ST_DONE
   } state_type;

   cfg_type cfg;

   state_type              state_ff;
   command_type            cmd_ff;
   logic [TS_W-1:0]        ts_ff;
   logic [BIN_INDEX_W-1:0] bin_index_ff;
   logic [TS_W-1:0]        diff_ff;
   logic [TS_W-1:0]        offset_ff;
   logic                   under_ff;
   logic                   hit_ff;
   logic [BIN_W-1:0]       addr_ff;
   logic                   min_lt_ff;
   logic                   max_gt_ff;
   logic [NUM_BINS-1:0]    bin_valid_ff;

   logic [TS_W-1:0] last_ts_ff;
   logic            have_prev_ff;
   count_type       over_ff;
   count_type       under_cnt_ff;
   logic [TS_W-1:0] min_ff;
   logic [TS_W-1:0] max_ff;

   count_type       over_in;
   count_type       under_cnt_in;
   logic [TS_W-1:0] min_in;
   logic [TS_W-1:0] max_in;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [OUT_W-1:0]       rsp_bin_ff;
   logic [OUT_W-1:0]       rsp_over_ff;
   logic [OUT_W-1:0]       rsp_under_ff;
   logic [TS_W-1:0]        rsp_min_ff;
   logic [TS_W-1:0]        rsp_max_ff;
   logic                   rsp_counted_ff;

   logic            accept;
   logic            commit;
   logic            sample_rec;
   logic            is_clear;
   logic [TS_W-1:0] bin_val;
   logic            look_hit;
   count_type       ram_rd_data;
   count_type       bin_cur;
   logic            ram_we;
   logic            ram_re;

   lhm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lhm_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (sat_inc(bin_cur)),
      .rd_en   (ram_re),
      .rd_addr (bin_val[BIN_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign sample_rec     = (cmd_ff == CMD_SAMPLE) && have_prev_ff;
   assign is_clear       = (cmd_ff == CMD_CLEAR);
   assign rsp_valid_in   = commit || (rsp_valid_ff && !rsp_chan.ready);

   assign bin_val  = (cmd_ff == CMD_READ_BIN) ? TS_W'(bin_index_ff)
                                              : (offset_ff >> cfg.bin_step_shift);
   assign look_hit = (bin_val < TS_W'(NUM_BINS));
   assign ram_re   = (state_ff == ST_LOOK);
   assign bin_cur  = bin_valid_ff[addr_ff] ? ram_rd_data : '0;
   assign ram_we   = commit && sample_rec && !under_ff && hit_ff;

   always_comb begin
      over_in      = over_ff;
      under_cnt_in = under_cnt_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      if (is_clear) begin
         over_in      = '0;
         under_cnt_in = '0;
         min_in       = S64_MAX;
         max_in       = S64_MIN;
      end else if (sample_rec) begin
         if (under_ff) begin
            under_cnt_in = sat_inc(under_cnt_ff);
         end else if (!hit_ff) begin
            over_in = sat_inc(over_ff);
         end
         if (min_lt_ff) begin
            min_in = diff_ff;
         end
         if (max_gt_ff) begin
            max_in = diff_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         last_ts_ff   <= '0;
         bin_valid_ff <= '0;
         over_ff      <= '0;
         under_cnt_ff <= '0;
         min_ff       <= S64_MAX;
         max_ff       <= S64_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff       <= command_type'(req_chan.command);
                  ts_ff        <= req_chan.timestamp;
                  bin_index_ff <= req_chan.bin_index;
                  state_ff     <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               diff_ff  <= ts_ff - last_ts_ff;
               state_ff <= ST_OFFS;
            end
            ST_OFFS: begin
               under_ff  <= $signed(diff_ff) < $signed({32'b0, cfg.range_start});
               offset_ff <= diff_ff - TS_W'(cfg.range_start);
               state_ff  <= ST_LOOK;
            end
            ST_LOOK: begin
               hit_ff    <= look_hit;
               addr_ff   <= bin_val[BIN_W-1:0];
               min_lt_ff <= $signed(diff_ff) < $signed(min_ff);
               max_gt_ff <= $signed(diff_ff) > $signed(max_ff);
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (commit) begin
                  over_ff      <= over_in;
                  under_cnt_ff <= under_cnt_in;
                  min_ff       <= min_in;
                  max_ff       <= max_in;
                  if (is_clear) begin
                     bin_valid_ff <= '0;
                     have_prev_ff <= 1'b0;
                     last_ts_ff   <= '0;
                  end else if (cmd_ff == CMD_SAMPLE) begin
                     have_prev_ff <= 1'b1;
                     last_ts_ff   <= ts_ff;
                  end
                  if (ram_we) begin
                     bin_valid_ff[addr_ff] <= 1'b1;
                  end
                  rsp_bin_ff     <= ((cmd_ff == CMD_READ_BIN) && hit_ff) ? cap_out(bin_cur)
                                                                         : '0;
                  rsp_over_ff    <= cap_out(over_in);
                  rsp_under_ff   <= cap_out(under_cnt_in);
                  rsp_min_ff     <= min_in;
                  rsp_max_ff     <= max_in;
                  rsp_counted_ff <= sample_rec;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.bin_count       = rsp_bin_ff;
   assign rsp_chan.overflow_count  = rsp_over_ff;
   assign rsp_chan.underflow_count = rsp_under_ff;
   assign rsp_chan.min_difference  = $signed(rsp_min_ff);
   assign rsp_chan.max_difference  = $signed(rsp_max_ff);
   assign rsp_chan.sample_counted  = rsp_counted_ff;

   a_bin_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> hit_ff && !under_ff && (cmd_ff == CMD_SAMPLE))
      else $error("Bin memory written for a difference outside the histogram.");

   a_counted_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_counted_ff |-> $signed(rsp_min_ff) <= $signed(rsp_max_ff))
      else $error("Recorded sample left the minimum above the maximum.");

   a_prime_cleared_by_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(have_prev_ff) |-> $past(commit) && $past(cmd_ff == CMD_CLEAR))
      else $error("Stored timestamp was unprimed without a clear command.");

   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready ##3 (state_ff == ST_DONE))
      else $error("Command word did not reach the update step in sequence.");

endmodule
